### sv/tape_pulse_byte_decoder_macros.svh
// Assertion macros shared by the tape pulse byte decoder.
`ifndef TAPE_PULSE_BYTE_DECODER_MACROS_SVH
`define TAPE_PULSE_BYTE_DECODER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TPBD_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TPBD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tpbd_pkg.sv
// Shared constants and types for the tape pulse byte decoder.
package tpbd_pkg;

    localparam int PULSE_BITS = 16;
    localparam int THR_BITS   = 16;
    localparam int CMP_BITS   = (PULSE_BITS > THR_BITS) ? PULSE_BITS : THR_BITS;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = THR_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_MEDIUM = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MEDIUM_LONG  = 1'd1;

    localparam logic [THR_BITS-1:0] SHORT_MEDIUM_RESET = 16'd426;
    localparam logic [THR_BITS-1:0] MEDIUM_LONG_RESET  = 16'd616;

    localparam logic [1:0] CLS_SHORT  = 2'd0;
    localparam logic [1:0] CLS_MEDIUM = 2'd1;
    localparam logic [1:0] CLS_LONG   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_PARITY = 2'd1;
    localparam logic [1:0] ST_EOD    = 2'd2;
    localparam logic [1:0] ST_SYNC   = 2'd3;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_SYNC = 2'd1;
    localparam logic [1:0] PH_BITS = 2'd2;

    localparam logic [3:0] DATA_BITS_COUNT = 4'd8;

    typedef struct packed {
        logic                  valid;
        logic [PULSE_BITS-1:0] len;
    } pulse_stage_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] cls;
    } cls_stage_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [3:0] bits;
    } frame_stat_t;

endpackage

### sv/tpbd_front.sv
// Threshold registers and the input stage that sorts each pulse into a class.
module tpbd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tpbd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tpbd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tpbd_pkg::PULSE_BITS-1:0]     pulse_length,
    input  logic                                advance,
    output tpbd_pkg::cls_stage_t                stage
);

    logic [tpbd_pkg::THR_BITS-1:0] sm_thr_reg;
    logic [tpbd_pkg::THR_BITS-1:0] ml_thr_reg;
    tpbd_pkg::pulse_stage_t        stage_reg;
    tpbd_pkg::pulse_stage_t        stage_next;
    logic [tpbd_pkg::CMP_BITS-1:0] len_ext;
    logic [1:0]                    cls;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_thr_reg <= tpbd_pkg::SHORT_MEDIUM_RESET;
            ml_thr_reg <= tpbd_pkg::MEDIUM_LONG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpbd_pkg::REG_SHORT_MEDIUM: sm_thr_reg <= cfg_data;
                tpbd_pkg::REG_MEDIUM_LONG:  ml_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = !stage_reg.valid || advance;

    always_comb
    begin
        stage_next = stage_reg;
        if (in_ready)
        begin
            stage_next.valid = in_valid;
            stage_next.len   = pulse_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else
            stage_reg <= stage_next;
    end

    assign len_ext = tpbd_pkg::CMP_BITS'(stage_reg.len);

    always_comb
    begin
        if (len_ext >= tpbd_pkg::CMP_BITS'(ml_thr_reg))
            cls = tpbd_pkg::CLS_LONG;
        else if (len_ext >= tpbd_pkg::CMP_BITS'(sm_thr_reg))
            cls = tpbd_pkg::CLS_MEDIUM;
        else
            cls = tpbd_pkg::CLS_SHORT;
    end

    assign stage.valid = stage_reg.valid;
    assign stage.cls   = cls;

endmodule

### sv/tpbd_framer.sv
// Frame state machine, bit pair decode, parity check and result register.
module tpbd_framer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tpbd_pkg::cls_stage_t   stage,
    output logic                   advance,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [7:0]             data_byte,
    output tpbd_pkg::frame_stat_t  stat
);

    logic [1:0] phase_reg,   phase_next;
    logic       in_block_reg, in_block_next;
    logic [3:0] bits_reg,    bits_next;
    logic [7:0] shift_reg,   shift_next;
    logic [1:0] first_reg,   first_next;
    logic       pend_reg,    pend_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg,  status_next;
    logic [7:0] data_reg,    data_next;
    logic       fire;
    logic       emit;
    logic [1:0] emit_status;
    logic [7:0] emit_data;
    logic       bit_val;
    logic       pair_ok;

    assign advance = !out_valid_reg || out_ready;
    assign fire    = stage.valid && advance;

    always_comb
    begin
        phase_next    = phase_reg;
        in_block_next = in_block_reg;
        bits_next     = bits_reg;
        shift_next    = shift_reg;
        first_next    = first_reg;
        pend_next     = pend_reg;
        emit          = 1'b0;
        emit_status   = tpbd_pkg::ST_SYNC;
        emit_data     = 8'd0;
        bit_val       = (first_reg == tpbd_pkg::CLS_MEDIUM);
        pair_ok       = (first_reg == tpbd_pkg::CLS_SHORT && stage.cls == tpbd_pkg::CLS_MEDIUM)
                     || (first_reg == tpbd_pkg::CLS_MEDIUM && stage.cls == tpbd_pkg::CLS_SHORT);
        if (fire)
        begin
            case (phase_reg)
                tpbd_pkg::PH_SYNC:
                begin
                    if (stage.cls == tpbd_pkg::CLS_MEDIUM)
                    begin
                        phase_next = tpbd_pkg::PH_BITS;
                        bits_next  = 4'd0;
                        shift_next = 8'd0;
                        pend_next  = 1'b0;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        emit_status = (stage.cls == tpbd_pkg::CLS_SHORT) ? tpbd_pkg::ST_EOD
                                                                         : tpbd_pkg::ST_SYNC;
                    end
                end
                tpbd_pkg::PH_BITS:
                begin
                    if (!pend_reg)
                    begin
                        first_next = stage.cls;
                        pend_next  = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (!pair_ok)
                            emit = 1'b1;
                        else if (bits_reg < tpbd_pkg::DATA_BITS_COUNT)
                        begin
                            shift_next = {bit_val, shift_reg[7:1]};
                            bits_next  = bits_reg + 4'd1;
                        end
                        else
                        begin
                            phase_next    = tpbd_pkg::PH_HUNT;
                            in_block_next = 1'b1;
                            bits_next     = 4'd0;
                            emit          = 1'b1;
                            emit_data     = shift_reg;
                            emit_status   = (bit_val ^ (^shift_reg)) ? tpbd_pkg::ST_OK
                                                                     : tpbd_pkg::ST_PARITY;
                        end
                    end
                end
                default:
                begin
                    phase_next = tpbd_pkg::PH_HUNT;
                    if (stage.cls == tpbd_pkg::CLS_LONG)
                        phase_next = tpbd_pkg::PH_SYNC;
                    else if (!(stage.cls == tpbd_pkg::CLS_SHORT && !in_block_reg))
                        emit = 1'b1;
                end
            endcase
            if (emit && (emit_status == tpbd_pkg::ST_EOD || emit_status == tpbd_pkg::ST_SYNC))
            begin
                phase_next    = tpbd_pkg::PH_HUNT;
                in_block_next = 1'b0;
                pend_next     = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        if (advance)
        begin
            out_valid_next = fire && emit;
            status_next    = emit_status;
            data_next      = emit_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tpbd_pkg::PH_HUNT;
            in_block_reg  <= 1'b0;
            bits_reg      <= 4'd0;
            shift_reg     <= 8'd0;
            first_reg     <= tpbd_pkg::CLS_SHORT;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            in_block_reg  <= in_block_next;
            bits_reg      <= bits_next;
            shift_reg     <= shift_next;
            first_reg     <= first_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign data_byte  = data_reg;
    assign stat.phase = phase_reg;
    assign stat.bits  = bits_reg;

endmodule

### sv/tape_pulse_byte_decoder.sv
// Top level of the tape pulse byte decoder.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------
//  in       | in_valid / in_ready   | pulse_length
//  out      | out_valid / out_ready | status, data_byte
//  cfg      | cfg_we (no wait)      | cfg_index, cfg_data
//
// A pulse is registered in the input register at its accepting edge, classified and run
// through the frame logic while it is held there, and any result it yields is registered
// in the result register when the framer advances. One pulse per cycle is sustained while
// results are taken; the result register is the only point of backpressure.
// A held result stalls a full input register, and in_ready drops only then.
// Reset restores the default thresholds and puts the framer in the hunt phase.
`include "tape_pulse_byte_decoder_macros.svh"

module tape_pulse_byte_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tpbd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tpbd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tpbd_pkg::PULSE_BITS-1:0]     pulse_length,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [7:0]                          data_byte
);

    tpbd_pkg::cls_stage_t  stage;
    tpbd_pkg::frame_stat_t stat;
    logic                  advance;

    tpbd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pulse_length (pulse_length),
        .advance      (advance),
        .stage        (stage)
    );

    tpbd_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data_byte (data_byte),
        .stat      (stat)
    );

    `TPBD_ASSERT_SAME(a_stall_only_on_backpressure, !in_ready, out_valid && !out_ready && stage.valid, "input stalled without output backpressure")
    `TPBD_ASSERT_SAME(a_marker_data_zero, out_valid && (status == tpbd_pkg::ST_EOD || status == tpbd_pkg::ST_SYNC), data_byte == 8'd0, "nonzero data with marker or sync error")
    `TPBD_ASSERT_SAME(a_bit_count_range, 1'b1, stat.bits <= tpbd_pkg::DATA_BITS_COUNT, "bit count past byte length")
    `TPBD_ASSERT_NEXT(a_byte_ends_frame, out_valid && (status == tpbd_pkg::ST_OK || status == tpbd_pkg::ST_PARITY) && !$past(out_valid), stat.bits == 4'd0 || stat.phase == tpbd_pkg::PH_BITS, "bit count not cleared after byte")

endmodule
